>>> src/micdc_pkg.sv
// shared types, widths and register codes for the microphone dc removal block
package micdc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 7;
   localparam int GATE_W   = 15;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PROD_W   = DIFF_W + GAIN_W + 1;
   localparam int DC_SHIFT = 8;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1);
   localparam logic [GATE_W-1:0] GATE_RESET = '0;

   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

   typedef enum logic [0:0] {
      REG_MIC_GAIN         = 1'b0,
      REG_NOISE_GATE_LEVEL = 1'b1
   } reg_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

>>> src/micdc_req_if.sv
// input channel: raw sample transaction
interface micdc_req_if;
   logic                  valid;
   logic                  ready;
   micdc_pkg::sample_type mic_sample;
   logic                  end_of_chunk;

   modport source (output valid, output mic_sample, output end_of_chunk, input ready);
   modport sink   (input valid, input mic_sample, input end_of_chunk, output ready);
endinterface

>>> src/micdc_rsp_if.sv
// result channel: conditioned sample transaction
interface micdc_rsp_if;
   logic                  valid;
   logic                  ready;
   micdc_pkg::sample_type clean_sample;
   logic                  end_of_chunk_out;

   modport source (output valid, output clean_sample, output end_of_chunk_out, input ready);
   modport sink   (input valid, input clean_sample, input end_of_chunk_out, output ready);
endinterface

>>> src/mic_dc_removal_gain_gate.sv
// top level: dc blocking filter with gain, saturation and noise gate
//
//   channel    direction  transaction          accepted when
//   req_chan   in         mic_sample, eoc      valid && ready
//   rsp_chan   out        clean_sample, eoc    valid && ready
//   csr_*      in/out     apb register access  psel && penable && pwrite && pready
//
// one transaction per cycle while results are taken; input register feeds result register
// the estimate and result come from one pass: subtract, shift, add, multiply, clamp, gate
// reset is synchronous and active high; gain resets to 1, gate level to 0, estimate to 0
// a stalled result holds both stages; the input stage still frees up as results drain
module mic_dc_removal_gain_gate (
   input  logic                                clock,
   input  logic                                reset,
   micdc_req_if.sink                           req_chan,
   micdc_rsp_if.source                         rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [micdc_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [micdc_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [micdc_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                                csr_pready
);

   logic [micdc_pkg::GAIN_W-1:0]   gain_ff, gain_in;
   logic [micdc_pkg::GATE_W-1:0]   gate_ff, gate_in;
   logic                           csr_write;
   micdc_pkg::reg_index_type       csr_index;

   logic                           s1_valid_ff, s1_valid_in;
   micdc_pkg::sample_type          s1_sample_ff, s1_sample_in;
   logic                           s1_eoc_ff, s1_eoc_in;

   logic                           out_valid_ff, out_valid_in;
   micdc_pkg::sample_type          out_sample_ff, out_sample_in;
   logic                           out_eoc_ff, out_eoc_in;

   micdc_pkg::sample_type          est_ff, est_in;

   logic                           out_load;
   logic                           s1_advance;
   logic                           req_take;

   logic signed [micdc_pkg::DIFF_W-1:0]   diff_a;
   logic signed [micdc_pkg::DIFF_W-1:0]   diff_round;
   logic signed [micdc_pkg::DIFF_W-1:0]   step;
   micdc_pkg::sample_type                 est_new;
   logic signed [micdc_pkg::DIFF_W-1:0]   diff_b;
   logic signed [micdc_pkg::PROD_W-1:0]   prod;
   logic signed [micdc_pkg::PROD_W-1:0]   prod_sat;
   logic signed [micdc_pkg::DIFF_W-1:0]   res_wide;
   logic signed [micdc_pkg::DIFF_W-1:0]   gate_pos;
   logic signed [micdc_pkg::DIFF_W-1:0]   gate_neg;
   micdc_pkg::sample_type                 result;

   function automatic logic signed [micdc_pkg::DIFF_W-1:0] DIFF_W_ext(
      input logic signed [micdc_pkg::SAMPLE_W-1:0] v
   );
      return {v[micdc_pkg::SAMPLE_W-1], v};
   endfunction

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = micdc_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      gain_in = gain_ff;
      gate_in = gate_ff;
      if (csr_write) begin
         case (csr_index)
            micdc_pkg::REG_MIC_GAIN:         gain_in = csr_pwdata[micdc_pkg::GAIN_W-1:0];
            micdc_pkg::REG_NOISE_GATE_LEVEL: gate_in = csr_pwdata[micdc_pkg::GATE_W-1:0];
            default: begin
               gain_in = gain_ff;
               gate_in = gate_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         micdc_pkg::REG_MIC_GAIN:
            csr_prdata = micdc_pkg::CSR_DW'(gain_ff);
         micdc_pkg::REG_NOISE_GATE_LEVEL:
            csr_prdata = micdc_pkg::CSR_DW'(gate_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // handshake
   assign out_load   = !out_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && out_load;
   assign req_chan.ready = !s1_valid_ff || out_load;
   assign req_take   = req_chan.valid && req_chan.ready;

   // dc estimate moves by (sample - estimate) / 256, truncated toward zero
   always_comb begin
      diff_a     = DIFF_W_ext(s1_sample_ff) - DIFF_W_ext(est_ff);
      diff_round = diff_a + (diff_a[micdc_pkg::DIFF_W-1]
                            ? micdc_pkg::DIFF_W'((1 << micdc_pkg::DC_SHIFT) - 1)
                            : micdc_pkg::DIFF_W'(0));
      step       = diff_round >>> micdc_pkg::DC_SHIFT;
      est_new    = est_ff + step[micdc_pkg::SAMPLE_W-1:0];
      diff_b     = DIFF_W_ext(s1_sample_ff) - DIFF_W_ext(est_new);
      prod       = micdc_pkg::PROD_W'(diff_b)
                 * $signed({{(micdc_pkg::PROD_W-micdc_pkg::GAIN_W){1'b0}}, gain_ff});
      if (prod > micdc_pkg::PROD_W'(micdc_pkg::SAT_MAX))
         prod_sat = micdc_pkg::PROD_W'(micdc_pkg::SAT_MAX);
      else if (prod < micdc_pkg::PROD_W'(micdc_pkg::SAT_MIN))
         prod_sat = micdc_pkg::PROD_W'(micdc_pkg::SAT_MIN);
      else
         prod_sat = prod;
      res_wide = prod_sat[micdc_pkg::DIFF_W-1:0];
      gate_pos = $signed({{(micdc_pkg::DIFF_W-micdc_pkg::GATE_W){1'b0}}, gate_ff});
      gate_neg = -gate_pos;
      if ((res_wide > gate_neg) && (res_wide < gate_pos))
         result = '0;
      else
         result = res_wide[micdc_pkg::SAMPLE_W-1:0];
   end

   // pipeline next state
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_eoc_in    = s1_eoc_ff;
      if (req_take) begin
         s1_valid_in  = 1'b1;
         s1_sample_in = req_chan.mic_sample;
         s1_eoc_in    = req_chan.end_of_chunk;
      end else if (s1_advance) begin
         s1_valid_in  = 1'b0;
      end

      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_eoc_in    = out_eoc_ff;
      est_in        = est_ff;
      if (s1_advance) begin
         out_valid_in  = 1'b1;
         out_sample_in = result;
         out_eoc_in    = s1_eoc_ff;
         est_in        = est_new;
      end else if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= micdc_pkg::GAIN_RESET;
         gate_ff      <= micdc_pkg::GATE_RESET;
         est_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         gate_ff      <= gate_in;
         est_ff       <= est_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff  <= s1_sample_in;
      s1_eoc_ff     <= s1_eoc_in;
      out_sample_ff <= out_sample_in;
      out_eoc_ff    <= out_eoc_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.clean_sample     = out_sample_ff;
   assign rsp_chan.end_of_chunk_out = out_eoc_ff;

endmodule

>>> dv/mic_dc_removal_gain_gate_test.sv
// self-checking testbench for the microphone dc removal, gain and noise gate block
`timescale 1ns / 100ps

module mic_dc_removal_gain_gate_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 125;

   typedef struct {
      micdc_pkg::sample_type clean_sample;
      logic                  end_of_chunk_out;
   } clean_result_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;
   typedef enum {SHAPE_UNIFORM, SHAPE_OFFSET, SHAPE_SQUARE, SHAPE_CORNER} sample_shape_type;

   logic clock = 1'b0;
   logic reset;

   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [micdc_pkg::CSR_AW-1:0] csr_paddr;
   logic [micdc_pkg::CSR_DW-1:0] csr_pwdata;
   logic [micdc_pkg::CSR_DW-1:0] csr_prdata;
   logic                         csr_pready;

   micdc_req_if req_chan();
   micdc_rsp_if rsp_chan();

   mic_dc_removal_gain_gate uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state and configuration copy
   int                           clean_dc_level = 0;
   logic [micdc_pkg::GAIN_W-1:0] gain_copy      = micdc_pkg::GAIN_RESET;
   logic [micdc_pkg::GATE_W-1:0] gate_copy      = micdc_pkg::GATE_RESET;

   clean_result_type  pending_clean[$];
   int                mismatch_count = 0;
   int                idle_cycles    = 0;
   int                burst_left     = 0;

   function automatic micdc_pkg::sample_type condition_sample(
      input micdc_pkg::sample_type raw
   );
      int prod;
      int gate;
      clean_dc_level = clean_dc_level +
                       (int'(raw) - clean_dc_level) / (1 << micdc_pkg::DC_SHIFT);
      prod = (int'(raw) - clean_dc_level) * int'(gain_copy);
      if (prod > int'(micdc_pkg::SAT_MAX)) prod = int'(micdc_pkg::SAT_MAX);
      if (prod < int'(micdc_pkg::SAT_MIN)) prod = int'(micdc_pkg::SAT_MIN);
      gate = int'(gate_copy);
      if (prod > -gate && prod < gate) prod = 0;
      return micdc_pkg::sample_type'(prod);
   endfunction

   function automatic micdc_pkg::sample_type clamp16(input int v);
      if (v > int'(micdc_pkg::SAT_MAX)) return micdc_pkg::SAT_MAX;
      if (v < int'(micdc_pkg::SAT_MIN)) return micdc_pkg::SAT_MIN;
      return micdc_pkg::sample_type'(v);
   endfunction

   // predict on accepted input, check on accepted result, follow register writes
   always @(posedge clock) begin
      clean_result_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            want.clean_sample     = condition_sample(req_chan.mic_sample);
            want.end_of_chunk_out = req_chan.end_of_chunk;
            pending_clean.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_clean.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected transaction: expected none actual clean_sample %0d eoc %0b",
                        $time, rsp_chan.clean_sample, rsp_chan.end_of_chunk_out);
            end else begin
               want = pending_clean.pop_front();
               if (rsp_chan.clean_sample !== want.clean_sample) begin
                  mismatch_count++;
                  $display("%0t clean_sample expected %0d actual %0d",
                           $time, want.clean_sample, rsp_chan.clean_sample);
               end
               if (rsp_chan.end_of_chunk_out !== want.end_of_chunk_out) begin
                  mismatch_count++;
                  $display("%0t end_of_chunk_out expected %0b actual %0b",
                           $time, want.end_of_chunk_out, rsp_chan.end_of_chunk_out);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (micdc_pkg::reg_index_type'(csr_paddr[micdc_pkg::CSR_AW-1:2]))
               micdc_pkg::REG_MIC_GAIN:
                  gain_copy = csr_pwdata[micdc_pkg::GAIN_W-1:0];
               micdc_pkg::REG_NOISE_GATE_LEVEL:
                  gate_copy = csr_pwdata[micdc_pkg::GATE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_psel && csr_penable) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog expired with %0d transactions outstanding",
                  $time, pending_clean.size());
         $display("mic_dc_removal_gain_gate: mismatch");
         $finish;
      end
   end

   // receiver stalls in a randomly chosen mode: never, at random, or on its own pattern
   stall_mode_type stall_mode    = STALL_NONE;
   int             stall_count   = 0;
   logic [15:0]    stall_pattern = 16'h0001;

   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_count   = $urandom_range(16, 96);
         stall_mode    = stall_mode_type'($urandom_range(0, 2));
         stall_pattern = 16'($urandom()) | 16'h0001;
      end
      stall_count--;
      case (stall_mode)
         STALL_NONE:   rsp_chan.ready <= 1'b1;
         STALL_RANDOM: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         default: begin
            rsp_chan.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         end
      endcase
   end

   task automatic send_sample(input micdc_pkg::sample_type raw, input logic eoc);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.mic_sample   <= raw;
      req_chan.end_of_chunk <= eoc;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (pending_clean.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input micdc_pkg::reg_index_type idx,
                                 input logic [micdc_pkg::CSR_DW-1:0] data);
      logic [micdc_pkg::CSR_DW-1:0] want_rd;
      drain_results();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= micdc_pkg::CSR_AW'(int'(idx) * 4);
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      case (idx)
         micdc_pkg::REG_MIC_GAIN:
            want_rd = micdc_pkg::CSR_DW'(data[micdc_pkg::GAIN_W-1:0]);
         micdc_pkg::REG_NOISE_GATE_LEVEL:
            want_rd = micdc_pkg::CSR_DW'(data[micdc_pkg::GATE_W-1:0]);
         default:
            want_rd = '0;
      endcase
      if (csr_prdata !== want_rd) begin
         mismatch_count++;
         $display("%0t csr_prdata expected %0h actual %0h", $time, want_rd, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic test_reset_extremes();
      send_sample(micdc_pkg::SAT_MAX, 1'b0);
      send_sample(micdc_pkg::SAT_MIN, 1'b1);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(micdc_pkg::SAT_MAX, 1'b0);
   endtask

   task automatic test_gain_zero();
      write_register(micdc_pkg::REG_MIC_GAIN, 32'd0);
      send_sample(micdc_pkg::SAT_MAX, 1'b0);
      send_sample(micdc_pkg::SAT_MIN, 1'b1);
   endtask

   // upper pwdata bits must be ignored
   task automatic test_gain_max_saturation();
      write_register(micdc_pkg::REG_MIC_GAIN, 32'hffff_ff80 | 32'd127);
      send_sample(micdc_pkg::SAT_MIN, 1'b0);
      send_sample(micdc_pkg::SAT_MAX, 1'b1);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd100, 1'b0);
   endtask

   // saturated values sit on the gate edge and must pass
   task automatic test_gate_levels();
      write_register(micdc_pkg::REG_MIC_GAIN, 32'd64);
      write_register(micdc_pkg::REG_NOISE_GATE_LEVEL, 32'hffff_8000 | 32'd32767);
      send_sample(micdc_pkg::SAT_MAX, 1'b0);
      send_sample(micdc_pkg::SAT_MIN, 1'b1);
      send_sample(16'sd5, 1'b0);
      send_sample(-16'sd5, 1'b0);
      write_register(micdc_pkg::REG_MIC_GAIN, 32'd1);
      write_register(micdc_pkg::REG_NOISE_GATE_LEVEL, 32'd1);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b1);
   endtask

   task automatic run_random_phase(input logic [micdc_pkg::GAIN_W-1:0] gain,
                                   input logic [micdc_pkg::GATE_W-1:0] gate,
                                   input int count);
      sample_shape_type shape;
      int level_a;
      int level_b;
      int noise;
      int hold;
      int v;
      shape   = SHAPE_UNIFORM;
      level_a = 0;
      level_b = 0;
      noise   = 0;
      hold    = 1;
      write_register(micdc_pkg::REG_MIC_GAIN,
                     (32'($urandom()) << micdc_pkg::GAIN_W) | 32'(gain));
      write_register(micdc_pkg::REG_NOISE_GATE_LEVEL,
                     (32'($urandom()) << micdc_pkg::GATE_W) | 32'(gate));
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            shape   = sample_shape_type'($urandom_range(0, 3));
            level_a = int'($urandom_range(0, 65535)) - 32768;
            level_b = int'($urandom_range(0, 65535)) - 32768;
            noise   = $urandom_range(0, 2000);
            hold    = $urandom_range(1, 60);
         end
         case (shape)
            SHAPE_UNIFORM: v = int'($urandom_range(0, 65535)) - 32768;
            SHAPE_OFFSET:  v = level_a + int'($urandom_range(0, 2 * noise)) - noise;
            SHAPE_SQUARE:  v = (((i / hold) % 2) ? level_a : level_b) +
                               int'($urandom_range(0, 64)) - 32;
            default: begin
               case ($urandom_range(0, 4))
                  0:       v = int'(micdc_pkg::SAT_MAX);
                  1:       v = int'(micdc_pkg::SAT_MIN);
                  2:       v = 0;
                  3:       v = -1;
                  default: v = int'($urandom_range(0, 65535)) - 32768;
               endcase
            end
         endcase
         send_sample(clamp16(v), ($urandom_range(0, 15) == 0));
      end
   endtask

   task automatic test_random_settings();
      run_random_phase(7'd0,   15'd32767, PHASE_ITEMS);
      run_random_phase(7'd127, 15'd0,     PHASE_ITEMS);
      run_random_phase(7'd64,  15'd32767, PHASE_ITEMS);
      run_random_phase(7'd1,   15'd0,     PHASE_ITEMS);
      for (int p = 0; p < 4; p++)
         run_random_phase(7'($urandom_range(0, 127)),
                          (p % 2) ? 15'($urandom()) : 15'($urandom_range(0, 2000)),
                          PHASE_ITEMS);
   endtask

   // sender holds off until every outstanding transaction has come back
   task automatic test_drain_pause();
      for (int i = 0; i < 15; i++)
         send_sample(micdc_pkg::sample_type'($urandom()), ($urandom_range(0, 7) == 0));
      drain_results();
      for (int i = 0; i < 15; i++)
         send_sample(micdc_pkg::sample_type'($urandom()), ($urandom_range(0, 7) == 0));
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.mic_sample   = '0;
      req_chan.end_of_chunk = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_reset_extremes();
      test_gain_zero();
      test_gain_max_saturation();
      test_gate_levels();
      test_random_settings();
      test_drain_pause();

      drain_results();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("mic_dc_removal_gain_gate: match");
      else
         $display("mic_dc_removal_gain_gate: mismatch");
      $finish;
   end

endmodule
